// ===== sv/ctg_pkg.sv =====
// Package for the charge temperature guard: word types, codes and threshold tables.
// Used by every module of the block; has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctg_pkg;

	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_GUARD_ON  = 3'd1;
	localparam logic [2:0] OP_GUARD_OFF = 3'd2;
	localparam logic [2:0] OP_SET_OVP   = 3'd3;
	localparam logic [2:0] OP_SET_LVD   = 3'd4;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_SKIPPED   = 3'd1;
	localparam logic [2:0] EV_STOPPED   = 3'd2;
	localparam logic [2:0] EV_RESUMED   = 3'd3;
	localparam logic [2:0] EV_AUTO_OFF  = 3'd4;

	localparam logic [1:0] MODE_OFF      = 2'd0;
	localparam logic [1:0] MODE_ARMED    = 2'd1;
	localparam logic [1:0] MODE_LIMITING = 2'd2;

	localparam logic [1:0] REG_TEMP_LOW  = 2'd0;
	localparam logic [1:0] REG_TEMP_HIGH = 2'd1;
	localparam logic [1:0] REG_INTERVAL  = 2'd2;

	localparam int          ADDR_W          = 4;
	localparam logic [7:0]  TEMP_LOW_RST    = 8'd0;
	localparam logic [7:0]  TEMP_HIGH_RST   = 8'd45;
	localparam logic [15:0] INTERVAL_RST    = 16'd5000;
	localparam logic [13:0] CRITICAL_MARGIN = 14'd300;

	localparam logic [12:0] OVP_MV [16] = '{
		13'd2700, 13'd2900, 13'd3100, 13'd3300, 13'd3400, 13'd3500, 13'd3600, 13'd3700,
		13'd3800, 13'd3900, 13'd4000, 13'd4100, 13'd4200, 13'd4300, 13'd4400, 13'd4500
	};
	localparam logic [12:0] LVD_MV [16] = '{
		13'd2200, 13'd2300, 13'd2400, 13'd2500, 13'd2600, 13'd2700, 13'd2800, 13'd2900,
		13'd3000, 13'd3100, 13'd3200, 13'd3300, 13'd3400, 13'd3500, 13'd3600, 13'd3700
	};

	typedef struct packed {
		logic [2:0]         operation;
		logic [31:0]        now_ms;
		logic signed [7:0]  temp_c;
		logic [15:0]        batt_mv;
		logic [15:0]        target_mv;
		logic [7:0]         reg_read;
	} req_word_t;

	typedef struct packed {
		logic        write_enable;
		logic [7:0]  write_value;
		logic [12:0] actual_mv;
		logic [1:0]  guard_mode;
		logic [2:0]  event_res;
	} rsp_word_t;

	typedef struct packed {
		logic signed [7:0] temp_low_limit;
		logic signed [7:0] temp_high_limit;
		logic [15:0]       tick_interval_ms;
	} cfg_t;

	function automatic logic [12:0] table_mv(input logic lvd, input logic [3:0] code);
		return lvd ? LVD_MV[code] : OVP_MV[code];
	endfunction

endpackage

`default_nettype wire

// ===== sv/charge_temperature_guard_core.sv =====
// Charge temperature guard: input register, decision logic, result register.
// A word is taken into the input register, decided, then held in the result register until taken.
// Throughput: one word per cycle unless rsp_ready stalls, set by the single decision stage and its state update.
// Reset: arst_n clears both valid flags and the guard state, loads register defaults.
// Depends on ctg_pkg, ctg_cfg, ctg_pick and ctg_step.
`timescale 1ns / 1ps
`default_nettype none

module charge_temperature_guard_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output      logic                       req_ready,
	input  wire ctg_pkg::req_word_t         req,
	output      logic                       rsp_valid,
	input  wire logic                       rsp_ready,
	output      ctg_pkg::rsp_word_t         rsp,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [ctg_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output      logic [31:0]                prdata,
	output      logic                       pready
);

	ctg_pkg::cfg_t      cfg;
	ctg_pkg::req_word_t item_s1;
	ctg_pkg::rsp_word_t result;
	ctg_pkg::rsp_word_t rsp_s2;
	logic               valid_s1;
	logic               valid_s2;
	logic               advance;
	logic               take;

	ctg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ctg_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign take      = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= req;
		end
		if (advance) begin
			rsp_s2 <= result;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

`default_nettype wire

// ===== sv/ctg_cfg.sv =====
// Configuration registers of the charge temperature guard behind an APB-style port.
// Depends on ctg_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module ctg_cfg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [ctg_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output      logic [31:0]               prdata,
	output      logic                      pready,
	output      ctg_pkg::cfg_t             cfg
);

	logic [7:0]  temp_low_q;
	logic [7:0]  temp_high_q;
	logic [15:0] interval_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_low_q  <= ctg_pkg::TEMP_LOW_RST;
			temp_high_q <= ctg_pkg::TEMP_HIGH_RST;
			interval_q  <= ctg_pkg::INTERVAL_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				ctg_pkg::REG_TEMP_LOW:  temp_low_q  <= pwdata[7:0];
				ctg_pkg::REG_TEMP_HIGH: temp_high_q <= pwdata[7:0];
				ctg_pkg::REG_INTERVAL:  interval_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ctg_pkg::REG_TEMP_LOW:  prdata = {24'd0, temp_low_q};
			ctg_pkg::REG_TEMP_HIGH: prdata = {24'd0, temp_high_q};
			ctg_pkg::REG_INTERVAL:  prdata = {16'd0, interval_q};
			default:                prdata = 32'd0;
		endcase
	end

	assign cfg.temp_low_limit   = temp_low_q;
	assign cfg.temp_high_limit  = temp_high_q;
	assign cfg.tick_interval_ms = interval_q;

endmodule

`default_nettype wire

// ===== sv/ctg_pick.sv =====
// Nearest threshold code for a millivolt target over a sorted 16-entry table.
// Depends on ctg_pkg for the OVP and LVD tables.
`timescale 1ns / 1ps
`default_nettype none

module ctg_pick (
	input  wire logic        sel_lvd,
	input  wire logic [15:0] target_mv,
	output      logic [3:0]  code,
	output      logic [12:0] mv
);

	logic [15:0] below;
	logic [4:0]  cnt;
	logic [3:0]  hi_idx;
	logic [3:0]  lo_idx;
	logic [13:0] pair_sum;
	logic [16:0] twice_target;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			below[i] = {3'd0, ctg_pkg::table_mv(sel_lvd, 4'(i))} < target_mv;
		end
	end

	// entries are ascending, so the set bits form a run from index 0
	always_comb begin
		cnt = 5'd0;
		for (int i = 0; i < 16; i++) begin
			if (below[i]) cnt = 5'(i + 1);
		end
	end

	assign hi_idx       = cnt[3:0];
	assign lo_idx       = 4'(cnt - 5'd1);
	assign pair_sum     = {1'b0, ctg_pkg::table_mv(sel_lvd, lo_idx)}
	                    + {1'b0, ctg_pkg::table_mv(sel_lvd, hi_idx)};
	assign twice_target = {target_mv, 1'b0};

	always_comb begin
		if (cnt == 5'd0) begin
			code = 4'd0;
		end else if (cnt[4]) begin
			code = 4'd15;
		end else if (twice_target <= {3'd0, pair_sum}) begin
			code = lo_idx;
		end else begin
			code = hi_idx;
		end
	end

	assign mv = ctg_pkg::table_mv(sel_lvd, code);

endmodule

`default_nettype wire

// ===== sv/ctg_step.sv =====
// Guard state and the per-word decision logic between the input and result registers.
// Depends on ctg_pkg and ctg_pick.
`timescale 1ns / 1ps
`default_nettype none

module ctg_step (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire ctg_pkg::req_word_t item,
	input  wire ctg_pkg::cfg_t      cfg,
	output      ctg_pkg::rsp_word_t result
);

	logic        guard_en_q,  guard_en_d;
	logic        guard_lim_q, guard_lim_d;
	logic [3:0]  sav_ovp_q,   sav_ovp_d;
	logic [3:0]  sav_lvd_q,   sav_lvd_d;
	logic [31:0] last_tick_q, last_tick_d;

	logic        in_range;
	logic        too_early;
	logic [31:0] elapsed;
	logic [13:0] critical;
	logic        batt_low;
	logic [3:0]  pick_code;
	logic [12:0] pick_mv;
	logic [7:0]  restore_byte;

	ctg_pick u_pick (
		.sel_lvd   (item.operation == ctg_pkg::OP_SET_LVD),
		.target_mv (item.target_mv),
		.code      (pick_code),
		.mv        (pick_mv)
	);

	assign in_range     = (item.temp_c >= cfg.temp_low_limit)
	                   && (item.temp_c <= cfg.temp_high_limit);
	assign elapsed      = item.now_ms - last_tick_q;
	assign too_early    = elapsed < {16'd0, cfg.tick_interval_ms};
	assign critical     = {1'b0, ctg_pkg::LVD_MV[sav_lvd_q]} + ctg_pkg::CRITICAL_MARGIN;
	assign batt_low     = (item.batt_mv != 16'd0) && (item.batt_mv < {2'd0, critical});
	assign restore_byte = {item.reg_read[7:4], sav_ovp_q};

	always_comb begin
		guard_en_d  = guard_en_q;
		guard_lim_d = guard_lim_q;
		sav_ovp_d   = sav_ovp_q;
		sav_lvd_d   = sav_lvd_q;
		last_tick_d = last_tick_q;
		result      = '0;

		unique case (item.operation)
			ctg_pkg::OP_TICK: begin
				if (too_early) begin
					result.event_res = ctg_pkg::EV_SKIPPED;
				end else begin
					last_tick_d = item.now_ms;
					if (guard_en_q && guard_lim_q) begin
						if (batt_low) begin
							result.write_enable = 1'b1;
							result.write_value  = restore_byte;
							result.event_res    = ctg_pkg::EV_AUTO_OFF;
							guard_lim_d         = 1'b0;
							guard_en_d          = 1'b0;
						end else if (in_range) begin
							result.write_enable = 1'b1;
							result.write_value  = restore_byte;
							result.event_res    = ctg_pkg::EV_RESUMED;
							guard_lim_d         = 1'b0;
						end
					end else if (guard_en_q && !in_range) begin
						result.write_enable = 1'b1;
						result.write_value  = {item.reg_read[7:4], 4'd0};
						result.event_res    = ctg_pkg::EV_STOPPED;
						guard_lim_d         = 1'b1;
					end
				end
			end
			ctg_pkg::OP_GUARD_ON: begin
				if (!guard_en_q) begin
					sav_ovp_d = item.reg_read[3:0];
					sav_lvd_d = item.reg_read[7:4];
				end
				guard_en_d  = 1'b1;
				guard_lim_d = 1'b0;
			end
			ctg_pkg::OP_GUARD_OFF: begin
				if (guard_lim_q) begin
					result.write_enable = 1'b1;
					result.write_value  = restore_byte;
				end
				guard_en_d  = 1'b0;
				guard_lim_d = 1'b0;
			end
			ctg_pkg::OP_SET_OVP: begin
				result.write_enable = 1'b1;
				result.write_value  = {item.reg_read[7:4], pick_code};
				result.actual_mv    = pick_mv;
				sav_ovp_d           = pick_code;
			end
			ctg_pkg::OP_SET_LVD: begin
				result.write_enable = 1'b1;
				result.write_value  = {pick_code, item.reg_read[3:0]};
				result.actual_mv    = pick_mv;
				sav_lvd_d           = pick_code;
			end
			default: ;
		endcase

		result.guard_mode = guard_lim_d ? ctg_pkg::MODE_LIMITING
		                  : (guard_en_d ? ctg_pkg::MODE_ARMED : ctg_pkg::MODE_OFF);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_en_q  <= 1'b0;
			guard_lim_q <= 1'b0;
			sav_ovp_q   <= 4'd0;
			sav_lvd_q   <= 4'd0;
			last_tick_q <= 32'd0;
		end else if (advance) begin
			guard_en_q  <= guard_en_d;
			guard_lim_q <= guard_lim_d;
			sav_ovp_q   <= sav_ovp_d;
			sav_lvd_q   <= sav_lvd_d;
			last_tick_q <= last_tick_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/ctg_checker.sv =====
// Port-level checks for charge_temperature_guard_core, attached by bind.
// Depends on ctg_pkg for the event and mode codes.
`timescale 1ns / 1ps
`default_nettype none

module ctg_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire ctg_pkg::rsp_word_t rsp
);

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.write_enable |-> rsp.write_value == 8'd0)
		else $error("write value without write enable");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.actual_mv != 13'd0 |-> rsp.write_enable)
		else $error("threshold reported without a write");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.event_res == ctg_pkg::EV_STOPPED
		|-> rsp.guard_mode == ctg_pkg::MODE_LIMITING && rsp.write_value[3:0] == 4'd0)
		else $error("charging stop without zero OVP code and limiting mode");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.event_res == ctg_pkg::EV_AUTO_OFF
		|-> rsp.guard_mode == ctg_pkg::MODE_OFF && rsp.write_enable)
		else $error("auto-disable left the guard on");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result word changed");

endmodule

bind charge_temperature_guard_core ctg_checker u_ctg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire

// ===== tb/sv/charge_temperature_guard_core_tb.sv =====
// Testbench for charge_temperature_guard_core: a directed table, then random phases with
// APB register settings and valid/ready idling; results checked against the table or a predictor.
// Depends on ctg_pkg and the charge_temperature_guard_core RTL.
`timescale 1ns / 1ps

module charge_temperature_guard_core_tb;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_WORDS = 1700;
	localparam int PHASES       = 8;

	localparam logic [2:0]  OP_RSVD_HI      = 3'd7;
	localparam logic [3:0]  OVP_CUTOFF_CODE = 4'd0;
	localparam logic [15:0] BATT_UNKNOWN    = 16'd0;
	localparam int          LOW_BATT_MARGIN = 300;

	localparam int OVP_TAB [16] = '{2700, 2900, 3100, 3300, 3400, 3500, 3600, 3700,
		3800, 3900, 4000, 4100, 4200, 4300, 4400, 4500};
	localparam int LVD_TAB [16] = '{2200, 2300, 2400, 2500, 2600, 2700, 2800, 2900,
		3000, 3100, 3200, 3300, 3400, 3500, 3600, 3700};

	localparam int PH_LO  [PHASES] = '{0, -128, 127, -20, 10, -128, 5, 127};
	localparam int PH_HI  [PHASES] = '{45, 127, -128, 60, 10, -128, 40, 127};
	localparam int PH_GAP [PHASES] = '{5000, 0, 65535, 1, 100, 65535, 1000, 0};
	localparam int PH_SND [PHASES] = '{0, 81, 0, 25, 0, 81, 0, 25};
	localparam int PH_RCV [PHASES] = '{0, 0, 81, 25, 0, 0, 81, 25};

	typedef struct {
		ctg_pkg::req_word_t w;
		bit                 typed;
		ctg_pkg::rsp_word_t want;
	} dir_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       req_valid;
	logic                       req_ready;
	ctg_pkg::req_word_t         req;
	logic                       rsp_valid;
	logic                       rsp_ready;
	ctg_pkg::rsp_word_t         rsp;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [ctg_pkg::ADDR_W-1:0] paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;

	logic signed [7:0]   lim_lo;
	logic signed [7:0]   lim_hi;
	logic [15:0]         tick_gap;
	logic                armed;
	logic                limiting;
	logic [3:0]          keep_ovp;
	logic [3:0]          keep_lvd;
	logic [31:0]         last_tick;

	ctg_pkg::rsp_word_t  awaited_rsp [$];
	dir_row_t            dir_tab [$];
	logic [7:0]          reg_img;
	logic [31:0]         t_now;
	int                  mismatches = 0;
	int                  cycles = 0;
	int                  snd_idle_pct = 0;
	int                  rcv_stall_pct = 0;

	charge_temperature_guard_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	function automatic logic [3:0] closest_code(input logic lvd, input logic [15:0] target);
		logic [3:0]  best;
		int unsigned best_d;
		int unsigned d;
		int unsigned v;
		best = 4'd0;
		best_d = 32'hFFFF_FFFF;
		for (int i = 0; i < 16; i++) begin
			v = lvd ? LVD_TAB[i] : OVP_TAB[i];
			d = (v > target) ? v - target : target - v;
			if (d < best_d) begin
				best_d = d;
				best = 4'(i);
			end
		end
		return best;
	endfunction

	function automatic ctg_pkg::rsp_word_t guard_next(input ctg_pkg::req_word_t w);
		ctg_pkg::rsp_word_t r;
		logic               in_range;
		logic [31:0]        since;
		int unsigned        critical;
		logic [3:0]         code;
		r = '0;
		in_range = ($signed(w.temp_c) >= lim_lo) && ($signed(w.temp_c) <= lim_hi);
		case (w.operation)
		ctg_pkg::OP_TICK: begin
			since = w.now_ms - last_tick;
			if (since < {16'd0, tick_gap}) begin
				r.event_res = ctg_pkg::EV_SKIPPED;
			end else begin
				last_tick = w.now_ms;
				if (armed) begin
					if (limiting) begin
						critical = LVD_TAB[keep_lvd] + LOW_BATT_MARGIN;
						if (w.batt_mv != BATT_UNKNOWN && w.batt_mv < critical) begin
							r.write_enable = 1'b1;
							r.write_value = {w.reg_read[7:4], keep_ovp};
							limiting = 1'b0;
							armed = 1'b0;
							r.event_res = ctg_pkg::EV_AUTO_OFF;
						end else if (in_range) begin
							r.write_enable = 1'b1;
							r.write_value = {w.reg_read[7:4], keep_ovp};
							limiting = 1'b0;
							r.event_res = ctg_pkg::EV_RESUMED;
						end
					end else if (!in_range) begin
						r.write_enable = 1'b1;
						r.write_value = {w.reg_read[7:4], OVP_CUTOFF_CODE};
						limiting = 1'b1;
						r.event_res = ctg_pkg::EV_STOPPED;
					end
				end
			end
		end
		ctg_pkg::OP_GUARD_ON: begin
			if (!armed) begin
				keep_ovp = w.reg_read[3:0];
				keep_lvd = w.reg_read[7:4];
			end
			armed = 1'b1;
			limiting = 1'b0;
		end
		ctg_pkg::OP_GUARD_OFF: begin
			if (limiting) begin
				r.write_enable = 1'b1;
				r.write_value = {w.reg_read[7:4], keep_ovp};
			end
			limiting = 1'b0;
			armed = 1'b0;
		end
		ctg_pkg::OP_SET_OVP: begin
			code = closest_code(1'b0, w.target_mv);
			r.write_enable = 1'b1;
			r.write_value = {w.reg_read[7:4], code};
			r.actual_mv = 13'(OVP_TAB[code]);
			keep_ovp = code;
		end
		ctg_pkg::OP_SET_LVD: begin
			code = closest_code(1'b1, w.target_mv);
			r.write_enable = 1'b1;
			r.write_value = {code, w.reg_read[3:0]};
			r.actual_mv = 13'(LVD_TAB[code]);
			keep_lvd = code;
		end
		default: ;
		endcase
		r.guard_mode = limiting ? ctg_pkg::MODE_LIMITING
			: (armed ? ctg_pkg::MODE_ARMED : ctg_pkg::MODE_OFF);
		return r;
	endfunction

	function automatic dir_row_t dir_row(input logic [2:0] op, input logic [31:0] now,
		input int temp, input logic [15:0] batt, input logic [15:0] tgt, input logic [7:0] rg,
		input bit typed, input ctg_pkg::rsp_word_t want);
		dir_row_t d;
		d.w = '{op, now, 8'(temp), batt, tgt, rg};
		d.typed = typed;
		d.want = want;
		return d;
	endfunction

	always @(posedge clk) begin : check_rsp
		ctg_pkg::rsp_word_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else if (rsp_valid && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: we=%0d wv=%02h mv=%0d mode=%0d ev=%0d",
						rsp.write_enable, rsp.write_value, rsp.actual_mv,
						rsp.guard_mode, rsp.event_res);
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.write_enable !== want.write_enable
						|| rsp.write_value !== want.write_value
						|| rsp.actual_mv !== want.actual_mv
						|| rsp.guard_mode !== want.guard_mode
						|| rsp.event_res !== want.event_res) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch: want we=%0d wv=%02h mv=%0d mode=%0d ev=%0d,",
							want.write_enable, want.write_value, want.actual_mv,
							want.guard_mode, want.event_res);
						$display(" got we=%0d wv=%02h mv=%0d mode=%0d ev=%0d",
							rsp.write_enable, rsp.write_value, rsp.actual_mv,
							rsp.guard_mode, rsp.event_res);
					end
				end
			end
		end
	end

	task automatic send_word(input ctg_pkg::req_word_t w, input bit typed,
		input ctg_pkg::rsp_word_t want);
		ctg_pkg::rsp_word_t predicted;
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (!req_ready);
		predicted = guard_next(w);
		if (predicted.write_enable)
			reg_img = predicted.write_value;
		awaited_rsp.push_back(typed ? want : predicted);
	endtask

	task automatic wait_all_results;
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ctg_pkg::ADDR_W'({idx, 2'b00});
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
		ctg_pkg::REG_TEMP_LOW: lim_lo = value[7:0];
		ctg_pkg::REG_TEMP_HIGH: lim_hi = value[7:0];
		ctg_pkg::REG_INTERVAL: tick_gap = value;
		default: ;
		endcase
	endtask

	task automatic make_word(output ctg_pkg::req_word_t w);
		int r;
		int t;
		int idx;
		int crit;
		r = $urandom_range(99);
		if (r < 40)
			w.operation = ctg_pkg::OP_TICK;
		else if (r < 50)
			w.operation = ctg_pkg::OP_GUARD_ON;
		else if (r < 57)
			w.operation = ctg_pkg::OP_GUARD_OFF;
		else if (r < 72)
			w.operation = ctg_pkg::OP_SET_OVP;
		else if (r < 87)
			w.operation = ctg_pkg::OP_SET_LVD;
		else
			w.operation = 3'($urandom_range(7));

		r = $urandom_range(99);
		if (r < 60)
			t_now = t_now + tick_gap + $urandom_range(200);
		else if (r < 78)
			t_now = t_now + $urandom_range(tick_gap);
		else if (r < 90)
			t_now = last_tick + tick_gap - $urandom_range(1);
		else
			t_now = $urandom;
		w.now_ms = t_now;

		r = $urandom_range(99);
		if (r < 35)
			t = int'(lim_lo) + int'($urandom_range(4)) - 2;
		else if (r < 70)
			t = int'(lim_hi) + int'($urandom_range(4)) - 2;
		else
			t = int'($urandom_range(255)) - 128;
		if (t < -128)
			t = -128;
		if (t > 127)
			t = 127;
		w.temp_c = 8'(t);

		crit = LVD_TAB[keep_lvd] + LOW_BATT_MARGIN;
		r = $urandom_range(99);
		if (r < 15)
			w.batt_mv = BATT_UNKNOWN;
		else if (r < 60)
			w.batt_mv = 16'(crit + int'($urandom_range(400)) - 200);
		else
			w.batt_mv = 16'($urandom_range(65535));

		idx = $urandom_range(14);
		r = $urandom_range(99);
		if (r < 20)
			w.target_mv = 16'((w.operation == ctg_pkg::OP_SET_LVD)
				? (LVD_TAB[idx] + LVD_TAB[idx + 1]) / 2
				: (OVP_TAB[idx] + OVP_TAB[idx + 1]) / 2);
		else if (r < 60)
			w.target_mv = 16'($urandom_range(4800, 2000));
		else
			w.target_mv = 16'($urandom_range(65535));

		w.reg_read = ($urandom_range(3) != 0) ? reg_img : 8'($urandom_range(255));
	endtask

	initial begin : stimulus
		ctg_pkg::req_word_t w;
		int                 sent;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		lim_lo = 8'sd0;
		lim_hi = 8'sd45;
		tick_gap = 16'd5000;
		armed = 1'b0;
		limiting = 1'b0;
		keep_ovp = 4'd0;
		keep_lvd = 4'd0;
		last_tick = 32'd0;
		reg_img = 8'h00;
		t_now = 32'd0;

		dir_tab.push_back(dir_row(ctg_pkg::OP_TICK, 32'd0,
			25, 16'd3700, 16'd0, 8'h00, 1'b1,
			'{1'b0, 8'h00, 13'd0, ctg_pkg::MODE_OFF, ctg_pkg::EV_SKIPPED}));
		dir_tab.push_back(dir_row(ctg_pkg::OP_TICK, 32'd5000,
			25, 16'd3700, 16'd0, 8'h00, 1'b1,
			'{1'b0, 8'h00, 13'd0, ctg_pkg::MODE_OFF, ctg_pkg::EV_NONE}));
		dir_tab.push_back(dir_row(OP_RSVD_HI, 32'hFFFF_FFFF,
			-128, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
			'{1'b0, 8'h00, 13'd0, ctg_pkg::MODE_OFF, ctg_pkg::EV_NONE}));
		dir_tab.push_back(dir_row(ctg_pkg::OP_SET_OVP, 32'd0,
			0, 16'd0, 16'd0, 8'hFF, 1'b1,
			'{1'b1, 8'hF0, 13'd2700, ctg_pkg::MODE_OFF, ctg_pkg::EV_NONE}));
		dir_tab.push_back(dir_row(ctg_pkg::OP_SET_OVP, 32'd0,
			0, 16'd0, 16'hFFFF, 8'h00, 1'b1,
			'{1'b1, 8'h0F, 13'd4500, ctg_pkg::MODE_OFF, ctg_pkg::EV_NONE}));
		dir_tab.push_back(dir_row(ctg_pkg::OP_SET_OVP, 32'd0,
			0, 16'd0, 16'd2800, 8'h5A, 1'b1,
			'{1'b1, 8'h50, 13'd2700, ctg_pkg::MODE_OFF, ctg_pkg::EV_NONE}));
		dir_tab.push_back(dir_row(ctg_pkg::OP_SET_LVD, 32'd0,
			0, 16'd0, 16'd0, 8'hFF, 1'b1,
			'{1'b1, 8'h0F, 13'd2200, ctg_pkg::MODE_OFF, ctg_pkg::EV_NONE}));
		dir_tab.push_back(dir_row(ctg_pkg::OP_SET_LVD, 32'd0,
			0, 16'd0, 16'hFFFF, 8'h00, 1'b1,
			'{1'b1, 8'hF0, 13'd3700, ctg_pkg::MODE_OFF, ctg_pkg::EV_NONE}));
		dir_tab.push_back(dir_row(ctg_pkg::OP_SET_LVD, 32'd0,
			0, 16'd0, 16'd2250, 8'h3C, 1'b1,
			'{1'b1, 8'h0C, 13'd2200, ctg_pkg::MODE_OFF, ctg_pkg::EV_NONE}));
		dir_tab.push_back(dir_row(ctg_pkg::OP_SET_LVD, 32'd0,
			0, 16'd0, 16'd3000, 8'h06, 1'b1,
			'{1'b1, 8'h86, 13'd3000, ctg_pkg::MODE_OFF, ctg_pkg::EV_NONE}));
		dir_tab.push_back(dir_row(ctg_pkg::OP_GUARD_ON, 32'd0,
			0, 16'd0, 16'd0, 8'h86, 1'b1,
			'{1'b0, 8'h00, 13'd0, ctg_pkg::MODE_ARMED, ctg_pkg::EV_NONE}));
		dir_tab.push_back(dir_row(ctg_pkg::OP_TICK, 32'd6000,
			60, 16'd4000, 16'd0, 8'h86, 1'b1,
			'{1'b0, 8'h00, 13'd0, ctg_pkg::MODE_ARMED, ctg_pkg::EV_SKIPPED}));
		dir_tab.push_back(dir_row(ctg_pkg::OP_TICK, 32'd10000,
			60, 16'd4000, 16'd0, 8'h86, 1'b1,
			'{1'b1, 8'h80, 13'd0, ctg_pkg::MODE_LIMITING, ctg_pkg::EV_STOPPED}));
		dir_tab.push_back(dir_row(ctg_pkg::OP_TICK, 32'd15000,
			60, 16'd4000, 16'd0, 8'h80, 1'b0, '0));
		dir_tab.push_back(dir_row(ctg_pkg::OP_TICK, 32'd20000,
			45, 16'd0, 16'd0, 8'h80, 1'b0, '0));
		dir_tab.push_back(dir_row(ctg_pkg::OP_TICK, 32'd25000,
			-1, 16'd3800, 16'd0, 8'h86, 1'b0, '0));
		dir_tab.push_back(dir_row(ctg_pkg::OP_TICK, 32'd30000,
			0, 16'd3299, 16'd0, 8'h80, 1'b0, '0));
		dir_tab.push_back(dir_row(ctg_pkg::OP_GUARD_ON, 32'd0,
			0, 16'd0, 16'd0, 8'h86, 1'b0, '0));
		dir_tab.push_back(dir_row(ctg_pkg::OP_TICK, 32'd35000,
			127, 16'hFFFF, 16'd0, 8'h86, 1'b0, '0));
		dir_tab.push_back(dir_row(ctg_pkg::OP_GUARD_ON, 32'd0,
			0, 16'd0, 16'd0, 8'h80, 1'b0, '0));
		dir_tab.push_back(dir_row(ctg_pkg::OP_TICK, 32'd40000,
			-128, 16'd3300, 16'd0, 8'h86, 1'b0, '0));
		dir_tab.push_back(dir_row(ctg_pkg::OP_GUARD_OFF, 32'd0,
			0, 16'd0, 16'd0, 8'h80, 1'b0, '0));
		dir_tab.push_back(dir_row(ctg_pkg::OP_TICK, 32'hFFFF_FFFF,
			20, 16'd0, 16'd0, 8'h86, 1'b0, '0));
		dir_tab.push_back(dir_row(ctg_pkg::OP_TICK, 32'd1000,
			20, 16'd0, 16'd0, 8'h86, 1'b0, '0));
		dir_tab.push_back(dir_row(ctg_pkg::OP_TICK, 32'd4999,
			20, 16'd0, 16'd0, 8'h86, 1'b0, '0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].want);
		reg_img = 8'h86;
		t_now = last_tick;

		for (int p = 0; p < PHASES; p++) begin
			wait_all_results();
			write_reg(ctg_pkg::REG_TEMP_LOW, {8'd0, 8'(PH_LO[p])});
			write_reg(ctg_pkg::REG_TEMP_HIGH, {8'd0, 8'(PH_HI[p])});
			write_reg(ctg_pkg::REG_INTERVAL, 16'(PH_GAP[p]));
			snd_idle_pct = PH_SND[p];
			rcv_stall_pct = PH_RCV[p];
			sent = 0;
			while (sent < RANDOM_WORDS / PHASES) begin
				make_word(w);
				send_word(w, 1'b0, '0);
				if (w.operation <= ctg_pkg::OP_SET_LVD)
					sent++;
			end
		end

		wait_all_results();
		if (mismatches == 0 && awaited_rsp.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
